// ----- src/ncac_pkg.sv -----
// ----------------------------------------------------------------------------
// ncac_pkg
// Shared sizes, stream layout, codes and internal types for the nearest centroid
// anomaly classifier.
// ----------------------------------------------------------------------------
package ncac_pkg;

	localparam int MAX_ENTRIES = 128;
	localparam int DIMENSIONS  = 5;
	localparam int COORD_BITS  = 16;

	localparam int IDX_BITS     = $clog2(MAX_ENTRIES);
	localparam int EIDX_BITS    = 7;
	localparam int RADIUS_BITS  = 16;
	localparam int LABEL_BITS   = 2;
	localparam int CFG_BITS     = 8;
	localparam int SQ_BITS      = 2 * COORD_BITS;
	localparam int DIST_BITS    = 35;
	localparam int RAD_SQ_BITS  = 2 * RADIUS_BITS;
	localparam int DECIDE_BITS  = 2;

	// input stream layout, lowest bits first
	localparam int IN_IDX_LSB    = 0;
	localparam int IN_COORD_LSB  = IN_IDX_LSB + EIDX_BITS;
	localparam int IN_RADIUS_LSB = IN_COORD_LSB + DIMENSIONS * COORD_BITS;
	localparam int IN_LABEL_LSB  = IN_RADIUS_LSB + RADIUS_BITS;
	localparam int IN_BITS       = IN_LABEL_LSB + LABEL_BITS;
	localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;

	// output stream layout, lowest bits first
	localparam int OUT_IDX_LSB     = 0;
	localparam int OUT_DIST_LSB    = OUT_IDX_LSB + EIDX_BITS;
	localparam int OUT_ANOM_LSB    = OUT_DIST_LSB + DIST_BITS;
	localparam int OUT_DECIDE_LSB  = OUT_ANOM_LSB + 1;
	localparam int OUT_BITS        = OUT_DECIDE_LSB + DECIDE_BITS;
	localparam int OUT_TDATA_BITS  = ((OUT_BITS + 7) / 8) * 8;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [LABEL_BITS-1:0] LABEL_PROVIDE = 2'd0;
	localparam logic [LABEL_BITS-1:0] LABEL_TAKE    = 2'd1;

	localparam logic [DECIDE_BITS-1:0] DECIDE_CANCEL  = 2'd0;
	localparam logic [DECIDE_BITS-1:0] DECIDE_TAKER   = 2'd1;
	localparam logic [DECIDE_BITS-1:0] DECIDE_PROVIDE = 2'd2;
	localparam logic [DECIDE_BITS-1:0] DECIDE_HOLD    = 2'd3;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [DIMENSIONS-1:0][COORD_BITS-1:0] coord_vec_t;
	typedef logic [DIMENSIONS-1:0][SQ_BITS-1:0] sq_vec_t;

	typedef struct packed {
		logic                en;
		logic [IDX_BITS-1:0] addr;
	} lane_wr_t;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [IDX_BITS-1:0] index;
	} scan_tag_t;

	typedef struct packed {
		logic                 done;
		logic [IDX_BITS-1:0]  index;
		logic [DIST_BITS-1:0] distance;
	} search_result_t;

endpackage

// ----- src/ncac_lane.sv -----
// ----------------------------------------------------------------------------
// ncac_lane
// One coordinate lane: holds that coordinate of every entry and returns the
// squared difference to the query point; the read is registered in data_s1, the square in sq_s2.
// ----------------------------------------------------------------------------
module ncac_lane import ncac_pkg::*; (
	input  logic                 clk,
	input  lane_wr_t             wr,
	input  coord_t               wr_data,
	input  logic [IDX_BITS-1:0]  rd_addr,
	input  coord_t               point,
	output logic [SQ_BITS-1:0]   sq_s2
);

	coord_t mem [MAX_ENTRIES];
	coord_t data_s1;

	logic signed [COORD_BITS:0] diff;
	coord_t                     mag;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr_data;
		end
		data_s1 <= mem[rd_addr];
	end

	always_comb begin
		diff = $signed({data_s1[COORD_BITS-1], data_s1}) - $signed({point[COORD_BITS-1], point});
		// magnitude always fits the coordinate width
		if (diff[COORD_BITS]) begin
			mag = COORD_BITS'(-diff);
		end else begin
			mag = diff[COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		sq_s2 <= SQ_BITS'(mag) * SQ_BITS'(mag);
	end

endmodule

// ----- src/ncac_merge.sv -----
// ----------------------------------------------------------------------------
// ncac_merge
// Sums the lane squares of each scanned entry and keeps the nearest one,
// lowest index on equal distance.
// ----------------------------------------------------------------------------
module ncac_merge import ncac_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  scan_tag_t      tag_s0,
	input  sq_vec_t        sq_s2,
	output search_result_t result
);

	scan_tag_t tag_s1, tag_s2, tag_s3;
	logic [DIST_BITS-1:0] sum_s3;
	logic [DIST_BITS-1:0] sum;
	logic [DIST_BITS-1:0] best_dist_q;
	logic [IDX_BITS-1:0]  best_idx_q;
	logic                 done_q;

	always_comb begin
		sum = '0;
		for (int d = 0; d < DIMENSIONS; d++) begin
			sum = sum + DIST_BITS'(sq_s2[d]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			done_q <= 1'b0;
		end else begin
			tag_s1 <= tag_s0;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			done_q <= tag_s3.valid && tag_s3.last;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3 <= sum;
		// scan always starts at entry zero, which seeds the search
		if (tag_s3.valid && ((tag_s3.index == '0) || (sum_s3 < best_dist_q))) begin
			best_dist_q <= sum_s3;
			best_idx_q  <= tag_s3.index;
		end
	end

	assign result.done     = done_q;
	assign result.index    = best_idx_q;
	assign result.distance = best_dist_q;

endmodule

// ----- src/nearest_centroid_anomaly_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// nearest_centroid_anomaly_classifier_unit
// Loads entries into a coordinate table and answers nearest entry queries
// with an anomaly flag and a decision.
// ----------------------------------------------------------------------------
// load request: written on accept, accepted back to back while idle
// query request: scans n = clamped entry_count entries, one entry per cycle,
//   all coordinates in parallel lanes; m_tvalid rises after the scan drains
//   and passes ST_LOOK, ST_MULT and ST_EMIT, later while an earlier result
//   still waits for m_tready; the next request is accepted only back in idle
// reset clears control and sets entry_count to 128; table contents are kept;
// the user must write entries before they are read, the block does not enforce it
module nearest_centroid_anomaly_classifier_unit import ncac_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_BITS-1:0]       cfg_wdata,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// entry_index, coord_0 .. coord_4, entry_radius, entry_label, zero pad
	input  logic [IN_TDATA_BITS-1:0]  s_tdata,
	// operation
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// best_index, best_distance_sq, anomaly, decision, zero pad
	output logic [OUT_TDATA_BITS-1:0] m_tdata
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_DRAIN = 3'd2;
	localparam logic [2:0] ST_LOOK  = 3'd3;
	localparam logic [2:0] ST_MULT  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]           state_q;
	logic [CFG_BITS-1:0]  count_q;
	logic [IDX_BITS-1:0]  last_q;
	logic [IDX_BITS-1:0]  cnt_q;
	coord_vec_t           point_q;
	coord_vec_t           in_coord;
	sq_vec_t              sq_s2;
	lane_wr_t             lane_wr;
	scan_tag_t            tag_s0;
	search_result_t       result;

	logic [RADIUS_BITS-1:0] radius_mem [MAX_ENTRIES];
	logic [LABEL_BITS-1:0]  label_mem  [MAX_ENTRIES];
	logic [RADIUS_BITS-1:0] rad_rd_q;
	logic [LABEL_BITS-1:0]  lab_rd_q;
	logic [RAD_SQ_BITS-1:0] rad_sq_q;

	logic                   out_valid_q;
	logic [OUT_BITS-1:0]    out_q;

	logic                   accept;
	logic                   is_load;
	logic [IDX_BITS-1:0]    last_idx;
	logic                   anomaly;
	logic [DECIDE_BITS-1:0] decision;
	logic                   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_load  = accept && (s_tuser == OP_LOAD)
		&& (32'(s_tdata[IN_IDX_LSB +: EIDX_BITS]) < MAX_ENTRIES);
	assign out_free = !out_valid_q || m_tready;

	assign lane_wr.en   = is_load;
	assign lane_wr.addr = IDX_BITS'(s_tdata[IN_IDX_LSB +: EIDX_BITS]);

	assign tag_s0.valid = (state_q == ST_SCAN);
	assign tag_s0.last  = (cnt_q == last_q);
	assign tag_s0.index = cnt_q;

	// count of zero searches one entry, too large a count saturates
	always_comb begin
		if (count_q == '0) begin
			last_idx = '0;
		end else if (32'(count_q) > MAX_ENTRIES) begin
			last_idx = IDX_BITS'(MAX_ENTRIES - 1);
		end else begin
			last_idx = IDX_BITS'(count_q - 1'b1);
		end
	end

	genvar d;
	generate
		for (d = 0; d < DIMENSIONS; d++) begin : g_lane
			assign in_coord[d] = s_tdata[IN_COORD_LSB + d * COORD_BITS +: COORD_BITS];

			ncac_lane u_lane (
				.clk     (clk),
				.wr      (lane_wr),
				.wr_data (in_coord[d]),
				.rd_addr (cnt_q),
				.point   (point_q[d]),
				.sq_s2   (sq_s2[d])
			);
		end
	endgenerate

	ncac_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s0 (tag_s0),
		.sq_s2  (sq_s2),
		.result (result)
	);

	always_ff @(posedge clk) begin
		if (is_load) begin
			radius_mem[lane_wr.addr] <= s_tdata[IN_RADIUS_LSB +: RADIUS_BITS];
			label_mem[lane_wr.addr]  <= s_tdata[IN_LABEL_LSB +: LABEL_BITS];
		end
		rad_rd_q <= radius_mem[result.index];
		lab_rd_q <= label_mem[result.index];
		rad_sq_q <= RAD_SQ_BITS'(rad_rd_q) * RAD_SQ_BITS'(rad_rd_q);
		if (accept) begin
			point_q <= in_coord;
		end
	end

	always_comb begin
		anomaly = result.distance > DIST_BITS'(rad_sq_q);
		if (anomaly) begin
			decision = DECIDE_CANCEL;
		end else if (lab_rd_q == LABEL_TAKE) begin
			decision = DECIDE_TAKER;
		end else if (lab_rd_q == LABEL_PROVIDE) begin
			decision = DECIDE_PROVIDE;
		end else begin
			decision = DECIDE_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= CFG_BITS'(MAX_ENTRIES);
			last_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				count_q <= cfg_wdata;
			end
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept && (s_tuser == OP_QUERY)) begin
						last_q  <= last_idx;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (tag_s0.last) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (result.done) begin
						state_q <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					state_q <= ST_MULT;
				end
				ST_MULT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_q[OUT_IDX_LSB +: EIDX_BITS]      <= EIDX_BITS'(result.index);
			out_q[OUT_DIST_LSB +: DIST_BITS]     <= result.distance;
			out_q[OUT_ANOM_LSB]                  <= anomaly;
			out_q[OUT_DECIDE_LSB +: DECIDE_BITS] <= decision;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_BITS'(out_q);

endmodule
